// File: hw/rtl/radec_to_lmn_with_slopes_core_assert.svh
// Assertion macros shared by the direction cosine core.
// Each use expands to one labeled concurrent assertion that reports with $error.
`ifndef RADEC_TO_LMN_WITH_SLOPES_CORE_ASSERT_SVH
`define RADEC_TO_LMN_WITH_SLOPES_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RDLMN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RDLMN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/rdlmn_pkg.sv
// Package of the direction cosine core: beat types, register codes and arithmetic helpers.
// Used by every module of the core; depends on nothing else.
package rdlmn_pkg;

   // Defaults of the top level parameters.
   localparam int ANGLE_WIDTH_DEF   = 32;
   localparam int CORDIC_STAGES_DEF = 30;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam logic [1:0] REG_REF_RA      = 2'd0;
   localparam logic [1:0] REG_REF_SIN_DEC = 2'd1;
   localparam logic [1:0] REG_REF_COS_DEC = 2'd2;

   // Fixed point constants.
   localparam logic [30:0]        REF_COS_DEC_RESET = 31'd1073741824;
   localparam logic signed [33:0] CORDIC_GAIN       = 34'sd652032874;
   localparam logic signed [31:0] S32_MAX           = 32'sh7FFFFFFF;
   localparam logic signed [31:0] S32_MIN           = 32'sh80000000;

   // Square root and divider sizes.
   localparam int ROOT_ARG_W = 61;
   localparam int ROOT_W     = 31;
   localparam int NUM_W      = 66;
   localparam int QUOT_W     = 32;

   // Input beat.
   typedef struct packed {
      logic [31:0]        ra;
      logic signed [31:0] dec;
      logic signed [31:0] ra_slope;
      logic signed [31:0] dec_slope;
      logic               ra_slope_valid;
      logic               dec_slope_valid;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic signed [31:0] l_cos;
      logic signed [31:0] m_cos;
      logic [30:0]        n_cos;
      logic signed [31:0] l_slope;
      logic signed [31:0] m_slope;
      logic signed [31:0] n_slope;
      logic               slope_present;
      logic               too_far;
   } rsp_type;

   // Data that travels alongside the CORDIC lanes.
   typedef struct packed {
      logic signed [31:0] dra_s;
      logic signed [31:0] ddec_s;
      logic               sp;
   } cs_side_type;

   // Data that travels alongside the square root.
   typedef struct packed {
      logic signed [31:0] l;
      logic signed [32:0] m;
      logic signed [31:0] dl;
      logic signed [31:0] dm;
      logic               far;
      logic               sp;
   } sq_side_type;

   // Data that travels alongside the divider.
   typedef struct packed {
      logic signed [31:0] l;
      logic signed [31:0] m;
      logic [30:0]        n;
      logic signed [31:0] dl;
      logic signed [31:0] dm;
      logic               far;
      logic               sp;
   } dv_side_type;

   // Arctangent of 2^-i as a fraction of a full turn, 32 bits.
   function automatic logic [31:0] atan_turns(input int i);
      logic [31:0] t;
      unique case (i)
         0:  t = 32'h20000000;
         1:  t = 32'h12E4051E;
         2:  t = 32'h09FB385B;
         3:  t = 32'h051111D4;
         4:  t = 32'h028B0D43;
         5:  t = 32'h0145D7E1;
         6:  t = 32'h00A2F61E;
         7:  t = 32'h00517C55;
         8:  t = 32'h0028BE53;
         9:  t = 32'h00145F2F;
         10: t = 32'h000A2F98;
         11: t = 32'h000517CC;
         12: t = 32'h00028BE6;
         13: t = 32'h000145F3;
         14: t = 32'h0000A2FA;
         15: t = 32'h0000517D;
         16: t = 32'h000028BE;
         17: t = 32'h0000145F;
         18: t = 32'h00000A30;
         19: t = 32'h00000518;
         20: t = 32'h0000028C;
         21: t = 32'h00000146;
         22: t = 32'h000000A3;
         23: t = 32'h00000051;
         24: t = 32'h00000029;
         25: t = 32'h00000014;
         26: t = 32'h0000000A;
         27: t = 32'h00000005;
         28: t = 32'h00000003;
         29: t = 32'h00000001;
         30: t = 32'h00000001;
         default: t = 32'h00000000;
      endcase
      return t;
   endfunction

   // Arctangent step rescaled to an angle of aw bits per turn; a right shift truncates.
   function automatic logic [47:0] atan_scaled(input int i, input int aw);
      logic [47:0] r;
      if (aw >= 32) begin
         r = 48'(atan_turns(i)) << (aw - 32);
      end else begin
         r = 48'(atan_turns(i) >> (32 - aw));
      end
      return r;
   endfunction

   // Q1.30 product with rounding: (a*b + 2^29) >>> 30.
   function automatic logic signed [33:0] mulq(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
      logic signed [67:0] p;
      p = 68'(a) * 68'(b) + 68'sd536870912;
      return p[63:30];
   endfunction

   // Clamp to the Q1.30 range of plus or minus one.
   function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v > 34'sd1073741824) begin
         r = 32'sd1073741824;
      end else if (v < -34'sd1073741824) begin
         r = -32'sd1073741824;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   // Saturate a wide value to the signed 32 bit range.
   function automatic logic signed [31:0] clamp_s32(input logic signed [66:0] v);
      logic signed [31:0] r;
      if (v > 67'sd2147483647) begin
         r = S32_MAX;
      end else if (v < -67'sd2147483648) begin
         r = S32_MIN;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/rdlmn_cordic.sv
// Two-lane pipelined rotation CORDIC giving the cosine and sine of two binary angles.
// Depends on rdlmn_pkg for the arctangent table, gain and clamp.
module rdlmn_cordic import rdlmn_pkg::*; #(
   parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
   parameter int SIDE_W        = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [1:0][31:0]  in_angle,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [1:0][31:0]  out_cos,
   output logic [1:0][31:0]  out_sin,
   output logic [SIDE_W-1:0] out_side
);

   localparam int XW = 34;
   localparam int ZW = ANGLE_WIDTH;
   localparam int NS = CORDIC_STAGES;

   logic signed [XW-1:0] x_ff [0:NS][2];
   logic signed [XW-1:0] y_ff [0:NS][2];
   logic signed [ZW-1:0] z_ff [0:NS][2];
   logic [1:0]           q_ff [0:NS][2];
   logic [NS+1:0]        valid_ff;
   logic [SIDE_W-1:0]    side_ff [0:NS+1];
   logic [ZW-1:0]        a_scaled [2];
   logic signed [31:0]   cos_in [2];
   logic signed [31:0]   sin_in [2];
   logic [1:0][31:0]     cos_ff;
   logic [1:0][31:0]     sin_ff;

   // Bring the 32 bit angles to the internal angle width.
   for (genvar k = 0; k < 2; k++) begin : g_scale
      if (ANGLE_WIDTH >= 32) begin : g_up
         assign a_scaled[k] = ZW'(in_angle[k]) << (ANGLE_WIDTH - 32);
      end else begin : g_down
         assign a_scaled[k] = ZW'(in_angle[k] >> (32 - ANGLE_WIDTH));
      end
   end

   // Entry stage: split off the quadrant and load the start vector.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 2; k++) begin
            x_ff[0][k] <= CORDIC_GAIN;
            y_ff[0][k] <= '0;
            z_ff[0][k] <= $signed({2'b00, a_scaled[k][ZW-3:0]});
            q_ff[0][k] <= a_scaled[k][ZW-1 -: 2];
         end
      end
   end

   // One micro-rotation per stage.
   for (genvar s = 0; s < NS; s++) begin : g_iter
      localparam logic signed [ZW-1:0] STEP = ZW'(atan_scaled(s, ANGLE_WIDTH));
      for (genvar k = 0; k < 2; k++) begin : g_lane
         always_ff @(posedge clock) begin
            if (en) begin
               if (!z_ff[s][k][ZW-1]) begin
                  x_ff[s+1][k] <= x_ff[s][k] - (y_ff[s][k] >>> s);
                  y_ff[s+1][k] <= y_ff[s][k] + (x_ff[s][k] >>> s);
                  z_ff[s+1][k] <= z_ff[s][k] - STEP;
               end else begin
                  x_ff[s+1][k] <= x_ff[s][k] + (y_ff[s][k] >>> s);
                  y_ff[s+1][k] <= y_ff[s][k] - (x_ff[s][k] >>> s);
                  z_ff[s+1][k] <= z_ff[s][k] + STEP;
               end
               q_ff[s+1][k] <= q_ff[s][k];
            end
         end
      end
   end

   // Quadrant fold and clamp to plus or minus one.
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         unique case (q_ff[NS][k])
            2'd0: begin
               cos_in[k] = clamp_q30(x_ff[NS][k]);
               sin_in[k] = clamp_q30(y_ff[NS][k]);
            end
            2'd1: begin
               cos_in[k] = clamp_q30(-y_ff[NS][k]);
               sin_in[k] = clamp_q30(x_ff[NS][k]);
            end
            2'd2: begin
               cos_in[k] = clamp_q30(-x_ff[NS][k]);
               sin_in[k] = clamp_q30(-y_ff[NS][k]);
            end
            default: begin
               cos_in[k] = clamp_q30(y_ff[NS][k]);
               sin_in[k] = clamp_q30(-x_ff[NS][k]);
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 2; k++) begin
            cos_ff[k] <= cos_in[k];
            sin_ff[k] <= sin_in[k];
         end
      end
   end

   // Valid bits and side data move with the stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[NS:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int s = 1; s <= NS + 1; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = valid_ff[NS+1];
   assign out_side  = side_ff[NS+1];
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;

endmodule

// File: hw/rtl/rdlmn_isqrt.sv
// Pipelined floor square root, one result bit per stage.
// Depends on rdlmn_pkg for the operand widths.
module rdlmn_isqrt import rdlmn_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [ROOT_ARG_W-1:0] in_value,
   input  logic [SIDE_W-1:0]     in_side,
   output logic                  out_valid,
   output logic [ROOT_W-1:0]     out_root,
   output logic [SIDE_W-1:0]     out_side
);

   localparam int RW = ROOT_W;

   logic [62:0]       rem_ff  [0:RW];
   logic [RW-1:0]     root_ff [0:RW];
   logic [RW:0]       valid_ff;
   logic [SIDE_W-1:0] side_ff [0:RW];

   // Entry stage.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= 63'(in_value);
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
      end
   end

   // Each stage decides one root bit, most significant first.
   for (genvar t = 0; t < RW; t++) begin : g_bit
      localparam int J = RW - 1 - t;
      logic [62:0] trial;
      assign trial = (63'(root_ff[t]) << (J + 1)) + (63'(1) << (2 * J));
      always_ff @(posedge clock) begin
         if (en) begin
            if (rem_ff[t] >= trial) begin
               rem_ff[t+1]  <= rem_ff[t] - trial;
               root_ff[t+1] <= root_ff[t] | (RW'(1) << J);
            end else begin
               rem_ff[t+1]  <= rem_ff[t];
               root_ff[t+1] <= root_ff[t];
            end
            side_ff[t+1] <= side_ff[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[RW-1:0], in_valid};
      end
   end

   assign out_valid = valid_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_side  = side_ff[RW];

endmodule

// File: hw/rtl/rdlmn_div.sv
// Pipelined signed divider giving the negated, saturated quotient -(num / den).
// Depends on rdlmn_pkg for widths and saturation limits.
module rdlmn_div import rdlmn_pkg::*; #(
   parameter int SIDE_W = 1
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  logic signed [NUM_W-1:0] in_num,
   input  logic [ROOT_W-1:0]       in_den,
   input  logic [SIDE_W-1:0]       in_side,
   output logic                    out_valid,
   output logic signed [31:0]      out_dn,
   output logic [SIDE_W-1:0]       out_side
);

   localparam int QW = QUOT_W;

   logic [ROOT_W-1:0]  rem_ff  [0:QW];
   logic [QW-1:0]      low_ff  [0:QW];
   logic [QW-1:0]      quo_ff  [0:QW];
   logic [ROOT_W-1:0]  den_ff  [0:QW];
   logic               neg_ff  [0:QW];
   logic               ovf_ff  [0:QW];
   logic [SIDE_W-1:0]  side_ff [0:QW+1];
   logic [QW+1:0]      valid_ff;
   logic [NUM_W-1:0]   mag;
   logic signed [31:0] dn_in;
   logic signed [31:0] dn_ff;

   // Entry stage: magnitude, overflow check and first partial remainder.
   assign mag = in_num[NUM_W-1] ? NUM_W'(-in_num) : NUM_W'(in_num);

   always_ff @(posedge clock) begin
      if (en) begin
         neg_ff[0] <= in_num[NUM_W-1];
         ovf_ff[0] <= mag[62:32] >= in_den;
         rem_ff[0] <= mag[62:32];
         low_ff[0] <= mag[31:0];
         quo_ff[0] <= '0;
         den_ff[0] <= in_den;
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar t = 0; t < QW; t++) begin : g_bit
      localparam int K = QW - 1 - t;
      logic [ROOT_W:0] r2;
      logic            ge;
      assign r2 = {rem_ff[t], low_ff[t][K]};
      assign ge = r2 >= {1'b0, den_ff[t]};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[t+1] <= ge ? ROOT_W'(r2 - {1'b0, den_ff[t]}) : r2[ROOT_W-1:0];
            quo_ff[t+1] <= quo_ff[t] | (QW'(ge) << K);
            low_ff[t+1] <= low_ff[t];
            den_ff[t+1] <= den_ff[t];
            neg_ff[t+1] <= neg_ff[t];
            ovf_ff[t+1] <= ovf_ff[t];
         end
      end
   end

   // Negate the quotient and saturate.
   always_comb begin
      if (ovf_ff[QW]) begin
         dn_in = neg_ff[QW] ? S32_MAX : S32_MIN;
      end else if (neg_ff[QW]) begin
         dn_in = quo_ff[QW][QW-1] ? S32_MAX : $signed(quo_ff[QW]);
      end else if (quo_ff[QW] > 32'h80000000) begin
         dn_in = S32_MIN;
      end else begin
         dn_in = 32'(-$signed({1'b0, quo_ff[QW]}));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dn_ff <= dn_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int s = 1; s <= QW + 1; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[QW:0], in_valid};
      end
   end

   assign out_valid = valid_ff[QW+1];
   assign out_dn    = dn_ff;
   assign out_side  = side_ff[QW+1];

endmodule

// File: hw/rtl/radec_to_lmn_with_slopes_core.sv
// Direction cosines l, m, n of a source against a phase reference, with propagated slopes.
// Top level; uses rdlmn_pkg, rdlmn_cordic, rdlmn_isqrt, rdlmn_div and the assertion macros.
//
// Usage:
//   req_valid/req_ready/req_data carry one source position per beat; rsp_valid/rsp_ready/
//   rsp_data carry one result beat per source, in the order the sources came in.
//   The APB port (psel, penable, pwrite, paddr, pwdata, prdata, pready) holds the phase
//   reference: ref_ra at 0x0, ref_sin_dec at 0x4, ref_cos_dec at 0x8. pready is tied high.
//   Write it only while no beats are in flight.
// Pipeline:
//   From acceptance to rsp_valid a beat passes the CORDIC rotations, four multiply stages,
//   a 31-step square root and a 32-step divider, one register each step. Throughput is
//   one beat per cycle while the output is not stalled.
// Reset:
//   Synchronous reset empties the pipeline and restores the reference registers
//   (ref_ra 0, ref_sin_dec 0, ref_cos_dec one).
// Stall:
//   While a result waits on rsp_ready, the whole pipeline holds and req_ready is low;
//   nothing is dropped or repeated. req_ready is high whenever the output is free to move.
module radec_to_lmn_with_slopes_core import rdlmn_pkg::*; #(
   parameter int ANGLE_WIDTH   = ANGLE_WIDTH_DEF,
   parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

`include "radec_to_lmn_with_slopes_core_assert.svh"

   // Reference registers.
   logic [31:0]        ref_ra_ff;
   logic signed [31:0] ref_sin_dec_ff;
   logic [30:0]        ref_cos_dec_ff;
   logic               csr_write;
   logic signed [31:0] sdec0;
   logic signed [31:0] cdec0;

   // Pipeline advance.
   logic en;

   // CORDIC.
   logic [1:0][31:0]  cord_angle;
   logic [1:0][31:0]  cord_cos;
   logic [1:0][31:0]  cord_sin;
   cs_side_type       cord_side_in;
   cs_side_type       cord_side;
   logic [$bits(cs_side_type)-1:0] cord_side_bits;
   logic              cord_valid;
   logic signed [31:0] cd, sd, cr, sr;

   // Stage B.
   logic               b_valid_ff, b_sp_ff;
   logic signed [31:0] b_l_ff, b_t1_ff, b_t2_ff, b_c3_ff, b_t4_ff, b_c4_ff, b_t5_ff;
   logic signed [31:0] b_cr_ff, b_dra_ff, b_ddec_ff;

   // Stage C.
   logic               c_valid_ff, c_sp_ff;
   logic signed [31:0] c_l_ff, c_c1_ff, c_c3_ff, c_c4_ff, c_dra_ff, c_ddec_ff;
   logic signed [32:0] c_m_ff, c_c2_ff;

   // Stage D.
   logic               d_valid_ff, d_sp_ff;
   logic signed [31:0] d_l_ff;
   logic signed [32:0] d_m_ff;
   logic signed [63:0] d_ll_ff;
   logic signed [65:0] d_mm_ff, d_p1_ff, d_p2_ff, d_p3_ff, d_p4_ff;

   // Stage E.
   logic signed [66:0] nks_in, sl_in, sm_in;
   logic               far_in;
   logic               e_valid_ff;
   logic [ROOT_ARG_W-1:0] e_arg_ff;
   sq_side_type        e_side_ff;

   // Square root.
   logic               sq_valid;
   logic [ROOT_W-1:0]  sq_root;
   logic [$bits(sq_side_type)-1:0] sq_side_bits;
   sq_side_type        sq_side;

   // Stages F and G.
   logic               f_valid_ff, g_valid_ff;
   logic signed [65:0] f_pl_ff, f_pm_ff, g_num_ff;
   logic [ROOT_W-1:0]  f_n_ff, g_den_ff;
   sq_side_type        f_side_ff;
   dv_side_type        g_side_ff;

   // Divider.
   logic               dv_valid;
   logic signed [31:0] dv_dn;
   logic [$bits(dv_side_type)-1:0] dv_side_bits;
   dv_side_type        dv_side;

   // Output register.
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;
   rsp_type            rsp_data_in;

   // Configuration port.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_ra_ff      <= '0;
         ref_sin_dec_ff <= '0;
         ref_cos_dec_ff <= REF_COS_DEC_RESET;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_REF_RA:      ref_ra_ff      <= pwdata;
            REG_REF_SIN_DEC: ref_sin_dec_ff <= $signed(pwdata);
            REG_REF_COS_DEC: ref_cos_dec_ff <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_REF_RA:      prdata = ref_ra_ff;
         REG_REF_SIN_DEC: prdata = ref_sin_dec_ff;
         REG_REF_COS_DEC: prdata = {1'b0, ref_cos_dec_ff};
         default:         prdata = '0;
      endcase
   end

   // Reference sine and cosine clamped to their valid ranges.
   assign sdec0 = clamp_q30(34'(ref_sin_dec_ff));
   assign cdec0 = (ref_cos_dec_ff > REF_COS_DEC_RESET) ? $signed({1'b0, REF_COS_DEC_RESET})
                                                       : $signed({1'b0, ref_cos_dec_ff});

   // The whole pipeline moves unless the output holds an untaken beat.
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // Sine and cosine of the hour angle offset (lane 0) and declination (lane 1).
   assign cord_angle[0] = req_data.ra - ref_ra_ff;
   assign cord_angle[1] = req_data.dec;
   assign cord_side_in.dra_s  = req_data.ra_slope_valid  ? req_data.ra_slope  : '0;
   assign cord_side_in.ddec_s = req_data.dec_slope_valid ? req_data.dec_slope : '0;
   assign cord_side_in.sp     = req_data.ra_slope_valid || req_data.dec_slope_valid;

   rdlmn_cordic #(
      .ANGLE_WIDTH   (ANGLE_WIDTH),
      .CORDIC_STAGES (CORDIC_STAGES),
      .SIDE_W        ($bits(cs_side_type))
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_angle  (cord_angle),
      .in_side   (cord_side_in),
      .out_valid (cord_valid),
      .out_cos   (cord_cos),
      .out_sin   (cord_sin),
      .out_side  (cord_side_bits)
   );

   assign cord_side = cs_side_type'(cord_side_bits);
   assign cr = $signed(cord_cos[0]);
   assign sr = $signed(cord_sin[0]);
   assign cd = $signed(cord_cos[1]);
   assign sd = $signed(cord_sin[1]);

   // Stage B: first rank of Q1.30 products.
   always_ff @(posedge clock) begin
      if (en) begin
         b_l_ff    <= 32'(mulq(34'(cd), 34'(sr)));
         b_t1_ff   <= 32'(mulq(34'(sd), 34'(cdec0)));
         b_t2_ff   <= 32'(mulq(34'(cd), 34'(sdec0)));
         b_c3_ff   <= 32'(mulq(34'(cd), 34'(cr)));
         b_t4_ff   <= 32'(mulq(34'(sd), 34'(sdec0)));
         b_c4_ff   <= 32'(-mulq(34'(sd), 34'(sr)));
         b_t5_ff   <= 32'(mulq(34'(cd), 34'(cdec0)));
         b_cr_ff   <= cr;
         b_dra_ff  <= cord_side.dra_s;
         b_ddec_ff <= cord_side.ddec_s;
         b_sp_ff   <= cord_side.sp;
      end
   end

   // Stage C: m and the slope coefficients.
   always_ff @(posedge clock) begin
      if (en) begin
         c_m_ff    <= 33'(b_t1_ff) - 33'(mulq(34'(b_t2_ff), 34'(b_cr_ff)));
         c_c2_ff   <= 33'(b_t5_ff) + 33'(mulq(34'(b_t4_ff), 34'(b_cr_ff)));
         c_c1_ff   <= 32'(mulq(34'(b_l_ff), 34'(sdec0)));
         c_l_ff    <= b_l_ff;
         c_c3_ff   <= b_c3_ff;
         c_c4_ff   <= b_c4_ff;
         c_dra_ff  <= b_dra_ff;
         c_ddec_ff <= b_ddec_ff;
         c_sp_ff   <= b_sp_ff;
      end
   end

   // Stage D: squares and exact slope products.
   always_ff @(posedge clock) begin
      if (en) begin
         d_ll_ff <= c_l_ff * c_l_ff;
         d_mm_ff <= c_m_ff * c_m_ff;
         d_p1_ff <= c_c1_ff * c_dra_ff;
         d_p2_ff <= c_c2_ff * c_ddec_ff;
         d_p3_ff <= c_c3_ff * c_dra_ff;
         d_p4_ff <= c_c4_ff * c_ddec_ff;
         d_l_ff  <= c_l_ff;
         d_m_ff  <= c_m_ff;
         d_sp_ff <= c_sp_ff;
      end
   end

   // Stage E: 1 - l^2 - m^2 at Q.60, and the rounded, saturated dl and dm.
   assign nks_in = 67'sd1152921504606846976 - 67'(d_ll_ff) - 67'(d_mm_ff);
   assign far_in = nks_in <= 67'sd0;
   assign sl_in  = 67'(d_p3_ff) + 67'(d_p4_ff) + 67'sd536870912;
   assign sm_in  = 67'(d_p1_ff) + 67'(d_p2_ff) + 67'sd536870912;

   always_ff @(posedge clock) begin
      if (en) begin
         e_arg_ff      <= far_in ? '0 : nks_in[ROOT_ARG_W-1:0];
         e_side_ff.l   <= d_l_ff;
         e_side_ff.m   <= d_m_ff;
         e_side_ff.dl  <= clamp_s32(sl_in >>> 30);
         e_side_ff.dm  <= clamp_s32(sm_in >>> 30);
         e_side_ff.far <= far_in;
         e_side_ff.sp  <= d_sp_ff;
      end
   end

   rdlmn_isqrt #(
      .SIDE_W ($bits(sq_side_type))
   ) u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (e_valid_ff),
      .in_value  (e_arg_ff),
      .in_side   (e_side_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side_bits)
   );

   assign sq_side = sq_side_type'(sq_side_bits);

   // Stage F: products for the numerator of dn.
   always_ff @(posedge clock) begin
      if (en) begin
         f_pl_ff   <= sq_side.l * sq_side.dl;
         f_pm_ff   <= sq_side.m * sq_side.dm;
         f_n_ff    <= sq_root;
         f_side_ff <= sq_side;
      end
   end

   // Stage G: numerator sum; a far source divides by one to keep the divider defined.
   always_ff @(posedge clock) begin
      if (en) begin
         g_num_ff      <= f_pl_ff + f_pm_ff;
         g_den_ff      <= f_side_ff.far ? ROOT_W'(1) : f_n_ff;
         g_side_ff.l   <= f_side_ff.l;
         g_side_ff.m   <= f_side_ff.m[31:0];
         g_side_ff.n   <= f_n_ff;
         g_side_ff.dl  <= f_side_ff.dl;
         g_side_ff.dm  <= f_side_ff.dm;
         g_side_ff.far <= f_side_ff.far;
         g_side_ff.sp  <= f_side_ff.sp;
      end
   end

   rdlmn_div #(
      .SIDE_W ($bits(dv_side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (g_valid_ff),
      .in_num    (g_num_ff),
      .in_den    (g_den_ff),
      .in_side   (g_side_ff),
      .out_valid (dv_valid),
      .out_dn    (dv_dn),
      .out_side  (dv_side_bits)
   );

   assign dv_side = dv_side_type'(dv_side_bits);

   // Output beat; a source that is too far reports zeros.
   always_comb begin
      rsp_data_in.slope_present = dv_side.sp;
      rsp_data_in.too_far       = dv_side.far;
      if (dv_side.far) begin
         rsp_data_in.l_cos   = '0;
         rsp_data_in.m_cos   = '0;
         rsp_data_in.n_cos   = '0;
         rsp_data_in.l_slope = '0;
         rsp_data_in.m_slope = '0;
         rsp_data_in.n_slope = '0;
      end else begin
         rsp_data_in.l_cos   = dv_side.l;
         rsp_data_in.m_cos   = dv_side.m;
         rsp_data_in.n_cos   = dv_side.n;
         rsp_data_in.l_slope = dv_side.dl;
         rsp_data_in.m_slope = dv_side.dm;
         rsp_data_in.n_slope = dv_dn;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // Valid bits of the top level stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         d_valid_ff   <= 1'b0;
         e_valid_ff   <= 1'b0;
         f_valid_ff   <= 1'b0;
         g_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         b_valid_ff   <= cord_valid;
         c_valid_ff   <= b_valid_ff;
         d_valid_ff   <= c_valid_ff;
         e_valid_ff   <= d_valid_ff;
         f_valid_ff   <= sq_valid;
         g_valid_ff   <= f_valid_ff;
         rsp_valid_ff <= dv_valid;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks on the result and on stall behavior.
   `RDLMN_ASSERT_SAME(a_far_zero, clock, reset,
      rsp_valid_ff && rsp_data_ff.too_far,
      rsp_data_ff.l_cos == '0 && rsp_data_ff.m_cos == '0 && rsp_data_ff.n_cos == '0 &&
      rsp_data_ff.l_slope == '0 && rsp_data_ff.m_slope == '0 && rsp_data_ff.n_slope == '0,
      "too far source with nonzero outputs")
   `RDLMN_ASSERT_SAME(a_no_slope_zero, clock, reset,
      rsp_valid_ff && !rsp_data_ff.slope_present,
      rsp_data_ff.l_slope == '0 && rsp_data_ff.m_slope == '0 && rsp_data_ff.n_slope == '0,
      "slopes nonzero without any input slope")
   `RDLMN_ASSERT_SAME(a_n_range, clock, reset,
      rsp_valid_ff,
      rsp_data_ff.n_cos <= REF_COS_DEC_RESET,
      "n above one")
   `RDLMN_ASSERT_NEXT(a_stall_hold, clock, reset,
      rsp_valid_ff && !rsp_ready,
      $stable(g_valid_ff) && $stable(e_valid_ff) && $stable(b_valid_ff),
      "pipeline moved during a stall")

endmodule

// File: tb/rdlmn_checker.sv
// Scoreboard for the direction cosine core: tracks register writes, predicts each result beat.
// Depends on rdlmn_pkg for the beat types and register codes.
module rdlmn_checker import rdlmn_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   input  logic                  pready,
   output int                    errors,
   output int                    pending,
   output int                    results_seen,
   output int                    far_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint ONE_Q30 = 64'sd1073741824;
   localparam longint GAIN    = 64'sd652032874;
   localparam longint SAT_HI  = 64'sd2147483647;
   localparam longint SAT_LO  = -64'sd2147483648;

   // Shadow copy of the phase reference registers.
   logic [31:0] phase_ra;
   logic [31:0] phase_sin;
   logic [30:0] phase_cos;

   rsp_type expected_lmn_q[$];

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint qmul(longint a, longint b);
      return (a * b + (64'sd1 <<< 29)) >>> 30;
   endfunction

   // Rotation CORDIC over the first quadrant, then folded out by the top two angle bits.
   function automatic void cordic_sincos(input logic [31:0] ang,
                                         output longint cv, output longint sv);
      longint x, y, z, xs, ys, cx, sy;
      x = GAIN;
      y = 0;
      z = longint'(ang[29:0]);
      for (int i = 0; i < 30; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'(atan_turns(i));
         end else begin
            x = x + ys; y = y - xs; z = z + longint'(atan_turns(i));
         end
      end
      case (ang[31:30])
         2'd0: begin cx = x;  sy = y;  end
         2'd1: begin cx = -y; sy = x;  end
         2'd2: begin cx = -x; sy = -y; end
         default: begin cx = y; sy = -x; end
      endcase
      cv = clip(cx, -ONE_Q30, ONE_Q30);
      sv = clip(sy, -ONE_Q30, ONE_Q30);
   endfunction

   // Floor square root, bit by bit.
   function automatic longint floor_root(longint arg);
      logic [63:0] v, r, b;
      v = arg;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   // Expected result beat for one source under the current reference.
   function automatic rsp_type predict_lmn(req_type s);
      rsp_type o;
      longint sd0, cd0, dra, ddec, cd, sd, cr, sr, l, m, nks, n;
      longint c1, c2, c3, c4, dl, dm, num, dn;
      sd0  = clip(longint'($signed(phase_sin)), -ONE_Q30, ONE_Q30);
      cd0  = clip(longint'(phase_cos), 0, ONE_Q30);
      dra  = s.ra_slope_valid ? longint'(s.ra_slope) : 0;
      ddec = s.dec_slope_valid ? longint'(s.dec_slope) : 0;
      cordic_sincos(s.dec, cd, sd);
      cordic_sincos(s.ra - phase_ra, cr, sr);
      l = qmul(cd, sr);
      m = qmul(sd, cd0) - qmul(qmul(cd, sd0), cr);
      nks = (64'sd1 <<< 60) - l * l - m * m;
      o = '0;
      o.slope_present = s.ra_slope_valid | s.dec_slope_valid;
      o.too_far = (nks <= 0);
      if (!o.too_far) begin
         n  = floor_root(nks);
         c1 = qmul(l, sd0);
         c2 = qmul(cd, cd0) + qmul(qmul(sd, sd0), cr);
         c3 = qmul(cd, cr);
         c4 = -qmul(sd, sr);
         dl = clip((c3 * dra + c4 * ddec + (64'sd1 <<< 29)) >>> 30, SAT_LO, SAT_HI);
         dm = clip((c1 * dra + c2 * ddec + (64'sd1 <<< 29)) >>> 30, SAT_LO, SAT_HI);
         num = l * dl + m * dm;
         dn = clip(-(num / n), SAT_LO, SAT_HI);
         o.l_cos   = l[31:0];
         o.m_cos   = m[31:0];
         o.n_cos   = n[30:0];
         o.l_slope = dl[31:0];
         o.m_slope = dm[31:0];
         o.n_slope = dn[31:0];
      end
      return o;
   endfunction

   task automatic compare_field(string name, longint want, longint got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   // Register writes, accepted source beats and result beats, all sampled at the edge.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         phase_ra  <= '0;
         phase_sin <= '0;
         phase_cos <= REF_COS_DEC_RESET;
         expected_lmn_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[3:2])
               REG_REF_RA:      phase_ra  <= pwdata;
               REG_REF_SIN_DEC: phase_sin <= pwdata;
               REG_REF_COS_DEC: phase_cos <= pwdata[30:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_lmn_q.push_back(predict_lmn(req_data));
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (rsp_data.too_far) far_seen++;
            if (expected_lmn_q.size() == 0) begin
               errors++;
               $display("%0t: result beat with nothing expected, actual %h", $time, rsp_data);
            end else begin
               want = expected_lmn_q.pop_front();
               compare_field("l_cos", $signed(want.l_cos), $signed(rsp_data.l_cos));
               compare_field("m_cos", $signed(want.m_cos), $signed(rsp_data.m_cos));
               compare_field("n_cos", want.n_cos, rsp_data.n_cos);
               compare_field("l_slope", $signed(want.l_slope), $signed(rsp_data.l_slope));
               compare_field("m_slope", $signed(want.m_slope), $signed(rsp_data.m_slope));
               compare_field("n_slope", $signed(want.n_slope), $signed(rsp_data.n_slope));
               compare_field("slope_present", want.slope_present, rsp_data.slope_present);
               compare_field("too_far", want.too_far, rsp_data.too_far);
            end
         end
      end
      pending = expected_lmn_q.size();
   end

   initial begin
      errors = 0;
      pending = 0;
      results_seen = 0;
      far_seen = 0;
   end

endmodule

// File: tb/testbench.sv
// Top of the direction cosine core testbench: clock, reset, register writes, source beats.
// Depends on rdlmn_pkg, radec_to_lmn_with_slopes_core and rdlmn_checker.
module testbench;
   import rdlmn_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DRAIN_CYCLES = 130;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;
   int                    errors;
   int                    pending;
   int                    results_seen;
   int                    far_seen;
   int                    sources_sent;
   int                    settings_used;
   bit                    calm;
   int                    hold_cnt;

   radec_to_lmn_with_slopes_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   rdlmn_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .errors(errors), .pending(pending), .results_seen(results_seen),
      .far_seen(far_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one, none while calm.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(15, 60);
   endfunction

   // Result side back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= 0;
      end else if (hold_cnt > 0) begin
         rsp_ready <= 1'b0;
         hold_cnt  <= hold_cnt - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (!calm && $urandom_range(0, 5) == 0) hold_cnt <= pick_gap();
      end
   end

   // One register write: setup phase, access phase, then idle with psel low.
   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Waits out everything in flight, then loads a new phase reference.
   task automatic set_reference(logic [31:0] ra0, logic [31:0] sin0, logic [31:0] cos0);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_write(REG_REF_RA, ra0);
      csr_write(REG_REF_SIN_DEC, sin0);
      csr_write(REG_REF_COS_DEC, cos0);
      settings_used++;
   endtask

   // Drives one source beat and holds it until accepted; ready is stable by the falling edge.
   task automatic send_source(req_type s);
      int gap;
      bit took;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= s;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      sources_sent++;
   endtask

   function automatic req_type make_source(logic [31:0] ra, logic [31:0] dec,
                                           logic [31:0] rs, logic [31:0] ds,
                                           logic rv, logic dv);
      req_type s;
      s.ra = ra; s.dec = dec; s.ra_slope = rs; s.dec_slope = ds;
      s.ra_slope_valid = rv; s.dec_slope_valid = dv;
      return s;
   endfunction

   // Random source: declination mostly inside the legal band, sometimes any angle.
   function automatic req_type random_source();
      logic [31:0] dec;
      logic [31:0] rs;
      logic [31:0] ds;
      if ($urandom_range(0, 9) == 0) dec = $urandom();
      else dec = $urandom_range(0, 32'h80000000) - 32'h40000000;
      rs = $urandom();
      ds = $urandom();
      // Small slopes are the common case; full range ones hit saturation.
      if ($urandom_range(0, 2) != 0) rs = {{8{rs[23]}}, rs[23:0]};
      if ($urandom_range(0, 2) != 0) ds = {{8{ds[23]}}, ds[23:0]};
      return make_source($urandom(), dec, rs, ds, 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)));
   endfunction

   task automatic random_batch(int count);
      for (int i = 0; i < count; i++) send_source(random_source());
   endtask

   initial begin
      int dec_sin;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      calm      = 1'b0;
      sources_sent = 0;
      settings_used = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed sources under the reset reference: quadrants, poles, slope extremes.
      send_source(make_source(32'h0, 32'h0, 32'h10000000, 32'h10000000, 1'b1, 1'b1));
      send_source(make_source(32'hFFFFFFFF, 32'h0, 32'h7FFFFFFF, 32'h80000000, 1'b1, 1'b1));
      send_source(make_source(32'h40000000, 32'h0, 32'h80000000, 32'h7FFFFFFF, 1'b1, 1'b1));
      send_source(make_source(32'h80000000, 32'h20000000, 32'h1, 32'h1, 1'b1, 1'b0));
      send_source(make_source(32'hC0000000, 32'hE0000000, 32'hFFFFFFFF, 32'h5, 1'b0, 1'b1));
      send_source(make_source(32'h12345678, 32'h40000000, 32'h10000000, 32'h10000000,
                              1'b1, 1'b1));
      send_source(make_source(32'h87654321, 32'hC0000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              1'b1, 1'b1));
      send_source(make_source(32'h20000000, 32'h3FFFFF00, 32'h7FFFFFFF, 32'h7FFFFFFF,
                              1'b1, 1'b1));
      send_source(make_source(32'h30000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                              1'b1, 1'b1));
      send_source(make_source(32'h50000000, 32'h80000000, 32'h80000000, 32'h80000000,
                              1'b1, 1'b1));
      send_source(make_source(32'hAAAAAAAA, 32'h15555555, 32'h55555555, 32'hAAAAAAAA,
                              1'b0, 1'b0));
      send_source(make_source(32'h55555555, 32'hEAAAAAAB, 32'hAAAAAAAA, 32'h55555555,
                              1'b1, 1'b1));
      random_batch(120);

      // Reference at the north pole.
      set_reference(32'h0, 32'h40000000, 32'h0);
      send_source(make_source(32'h0, 32'h40000000, 32'h10000000, 32'h10000000, 1'b1, 1'b1));
      send_source(make_source(32'h40000000, 32'h0, 32'h10000000, 32'h10000000, 1'b1, 1'b1));
      random_batch(140);

      // Reference at the south pole, right ascension at its top value; no idling here.
      calm = 1'b1;
      set_reference(32'hFFFFFFFF, 32'hC0000000, 32'h0);
      random_batch(150);
      calm = 1'b0;

      // Registers beyond their range must be clamped where used.
      set_reference(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
      send_source(make_source(32'h80000000, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0));
      random_batch(120);
      set_reference(32'h7FFFFFFF, 32'h80000000, 32'h40000001);
      random_batch(100);

      // A few random references at realistic declinations.
      for (int k = 0; k < 3; k++) begin
         dec_sin = $urandom_range(0, 32'h7FFFFFFF) - 32'h3FFFFFFF;
         set_reference($urandom(), dec_sin, $urandom_range(0, 32'h40000000));
         random_batch(100);
      end

      // Back to the reset values of the reference.
      set_reference(32'h0, 32'h0, REF_COS_DEC_RESET);
      random_batch(30);

      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d sources under %0d reference settings; %0d results checked.",
               sources_sent, settings_used + 1, results_seen);
      $display("%0d results flagged too far.", far_seen);
      if (errors == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #20ms;
      $display("testbench failed");
      $finish;
   end

endmodule
